### src/muaw_pkg.sv
// Shared types and constants for the multi-turn encoder angle unwrap block.
`timescale 1ns / 1ps

package muaw_pkg;

	// Units of one full turn: 360 degrees in 1/64 degree.
	localparam int unsigned TURN_UNITS = 23040;
	localparam int unsigned GAIN_FRAC = 24;
	localparam int unsigned ANGLE_W = 15;
	localparam int unsigned GAIN_W = 32;
	localparam int unsigned INTERVAL_W = 8;

	// One turn is 45 * 2^9 units, and 2^12 leaves a remainder of 1 when divided by 45.
	localparam int unsigned MOD_LOW_W = 9;
	localparam int unsigned MOD_ODD = 45;
	localparam int unsigned FOLD_W = 12;
	// floor(x * 2913 / 2^17) equals floor(x / 45) for every x up to 4096.
	localparam int unsigned MOD_RECIP = 2913;
	localparam int unsigned MOD_RECIP_SH = 17;

	// Reset values of the configuration registers and of the zero point.
	localparam logic signed [GAIN_W-1:0] GAIN_RESET = -32'sd683056;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd10;
	localparam int unsigned ZERO_TURNS_RESET = 16;
	localparam logic [ANGLE_W-1:0] ZERO_ANGLE_RESET = 15'd20288;

	// Configuration register indexes.
	localparam logic CFG_GEAR_GAIN = 1'b0;
	localparam logic CFG_FIRE_INTERVAL = 1'b1;

	typedef struct packed {
		logic full;
		logic empty;
	} muaw_fifo_status_t;

	typedef struct packed {
		logic busy;
		logic out_load;
	} muaw_back_status_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SCALE,
		B_FOLD,
		B_REDUCE,
		B_MOD,
		B_OUT
	} muaw_back_state_t;

endpackage

### src/muaw_front.sv
// Front part: sample counting, zero capture and turn-offset formation.
`timescale 1ns / 1ps

module muaw_front #(
	parameter int unsigned TURN_BITS = 12,
	parameter int unsigned OFF_W = TURN_BITS + 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [TURN_BITS-1:0]                turn_count,
	input  logic [muaw_pkg::ANGLE_W-1:0]        single_turn_angle,
	input  logic                                zero_request,
	input  logic [muaw_pkg::INTERVAL_W-1:0]     fire_interval,
	input  muaw_pkg::muaw_fifo_status_t         fifo_status,
	output logic                                fifo_push,
	output logic [OFF_W-1:0]                    fifo_wdata
);
	import muaw_pkg::*;

	localparam logic signed [OFF_W-1:0] UNITS_S = OFF_W'(TURN_UNITS);

	logic [INTERVAL_W-1:0] counter_q;
	logic                  pending_q;
	logic [TURN_BITS-1:0]  zero_turns_q;
	logic [ANGLE_W-1:0]    zero_angle_q;

	logic                  accept;
	logic                  pend_or;
	logic [INTERVAL_W:0]   next_count;
	logic                  act;
	logic [TURN_BITS-1:0]  d;
	logic signed [OFF_W-1:0] diff_ext;
	logic signed [OFF_W-1:0] angle_ext;
	logic signed [OFF_W-1:0] zero_ext;
	logic signed [OFF_W-1:0] offset;

	assign accept = push & ~fifo_status.full;
	assign pend_or = pending_q | zero_request;
	// The increment is taken one bit wider so that an interval of 255 still fires.
	assign next_count = {1'b0, counter_q} + 1'b1;
	assign act = next_count > {1'b0, fire_interval};

	assign d = turn_count - zero_turns_q;
	assign diff_ext = OFF_W'($signed(d));
	assign angle_ext = $signed({{(OFF_W-ANGLE_W){1'b0}}, single_turn_angle});
	assign zero_ext = $signed({{(OFF_W-ANGLE_W){1'b0}}, zero_angle_q});
	assign offset = OFF_W'(diff_ext * UNITS_S) + angle_ext - zero_ext;

	assign fifo_push = accept & act & ~pend_or;
	assign fifo_wdata = offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			pending_q <= 1'b0;
			zero_turns_q <= TURN_BITS'(ZERO_TURNS_RESET);
			zero_angle_q <= ZERO_ANGLE_RESET;
		end else if (accept) begin
			if (!act) begin
				counter_q <= next_count[INTERVAL_W-1:0];
				pending_q <= pend_or;
			end else begin
				counter_q <= '0;
				pending_q <= 1'b0;
				if (pend_or) begin
					zero_turns_q <= turn_count;
					zero_angle_q <= single_turn_angle;
				end
			end
		end
	end

endmodule

### src/muaw_fifo.sv
// Two-entry queue carrying turn offsets from the front to the back.
`timescale 1ns / 1ps

module muaw_fifo #(
	parameter int unsigned WIDTH = 28
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [WIDTH-1:0]            wdata,
	input  logic                        pop,
	output logic [WIDTH-1:0]            rdata,
	output muaw_pkg::muaw_fifo_status_t status
);
	import muaw_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full = count_q == 2'd2;
	assign status.empty = count_q == 2'd0;
	assign do_push = push & ~status.full;
	assign do_pop = pop & ~status.empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/muaw_back.sv
// Back part: gain multiply, floor shift and wrap into one turn by remainder folding.
`timescale 1ns / 1ps

module muaw_back #(
	parameter int unsigned OFF_W = 28
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [OFF_W-1:0]                    fifo_rdata,
	input  muaw_pkg::muaw_fifo_status_t         fifo_status,
	output logic                                fifo_pop,
	input  logic signed [muaw_pkg::GAIN_W-1:0]  gear_gain,
	input  logic                                pop,
	output logic                                empty,
	output logic [muaw_pkg::ANGLE_W-1:0]        output_angle,
	output muaw_pkg::muaw_back_status_t         status
);
	import muaw_pkg::*;

	localparam int unsigned P_W = OFF_W + GAIN_W;
	localparam int unsigned Q_W = P_W - GAIN_FRAC;
	localparam int unsigned HI_W = 3 * FOLD_W;
	localparam int unsigned RP_W = 2 * FOLD_W + 1;
	localparam int unsigned QUO_W = RP_W - MOD_RECIP_SH;
	localparam int unsigned ODD_W = ANGLE_W - MOD_LOW_W;
	localparam logic [ANGLE_W-1:0] UNITS_R = ANGLE_W'(TURN_UNITS);

	muaw_back_state_t state_q;
	muaw_back_state_t state_d;

	logic signed [P_W-1:0] prod_s1;
	logic [Q_W-1:0]        mag_q;
	logic                  neg_q;
	logic                  pos_q;
	logic [MOD_LOW_W-1:0]  low_q;
	logic [FOLD_W+1:0]     fold1_q;
	logic [FOLD_W:0]       fold_q;
	logic [ANGLE_W-1:0]    rem_q;
	logic                  out_valid_q;
	logic [ANGLE_W-1:0]    out_q;

	logic                  load_prod;
	logic                  load_mag;
	logic                  fold_step;
	logic                  reduce_step;
	logic                  mod_step;
	logic                  out_load;
	logic                  out_free;

	logic signed [P_W-1:0] q_full;
	logic signed [Q_W-1:0] q;
	logic                  q_pos;
	logic signed [Q_W-1:0] v;
	logic [HI_W-1:0]       hi;
	logic [FOLD_W+1:0]     fold1;
	logic [FOLD_W:0]       fold2;
	logic [FOLD_W:0]       fold3;
	logic [QUO_W-1:0]      quo;
	logic [ODD_W-1:0]      odd_rem;
	logic [ANGLE_W-1:0]    r;
	logic [ANGLE_W-1:0]    result;

	assign out_free = ~out_valid_q | pop;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!fifo_status.empty) begin
					state_d = B_SCALE;
				end
			end
			B_SCALE: state_d = B_FOLD;
			B_FOLD: state_d = B_REDUCE;
			B_REDUCE: state_d = B_MOD;
			B_MOD: state_d = B_OUT;
			B_OUT: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		load_prod = 1'b0;
		load_mag = 1'b0;
		fold_step = 1'b0;
		reduce_step = 1'b0;
		mod_step = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_IDLE: load_prod = ~fifo_status.empty;
			B_SCALE: load_mag = 1'b1;
			B_FOLD: fold_step = 1'b1;
			B_REDUCE: reduce_step = 1'b1;
			B_MOD: mod_step = 1'b1;
			B_OUT: out_load = out_free;
			default: ;
		endcase
	end

	assign fifo_pop = load_prod;

	// A positive value is wrapped as (q - 1) mod M + 1, so whole positive turns give M.
	assign q_full = prod_s1 >>> GAIN_FRAC;
	assign q = q_full[Q_W-1:0];
	assign q_pos = ~q[Q_W-1] & (q != '0);
	assign v = q_pos ? q - Q_W'(1) : q;

	// The low nine bits of the magnitude pass straight through; the rest is reduced by 45.
	// Adding its 12-bit digits keeps that remainder, since 4096 leaves 1 by 45.
	assign hi = HI_W'(mag_q[Q_W-1:MOD_LOW_W]);
	assign fold1 = (FOLD_W + 2)'(hi[FOLD_W-1:0]) + (FOLD_W + 2)'(hi[2*FOLD_W-1:FOLD_W])
		+ (FOLD_W + 2)'(hi[3*FOLD_W-1:2*FOLD_W]);
	assign fold2 = (FOLD_W + 1)'(fold1_q[FOLD_W-1:0]) + (FOLD_W + 1)'(fold1_q[FOLD_W+1:FOLD_W]);
	assign fold3 = (FOLD_W + 1)'(fold2[FOLD_W-1:0]) + (FOLD_W + 1)'(fold2[FOLD_W]);

	assign quo = QUO_W'((RP_W'(fold_q) * RP_W'(MOD_RECIP)) >> MOD_RECIP_SH);
	assign odd_rem = ODD_W'(fold_q - (FOLD_W + 1)'(quo) * (FOLD_W + 1)'(MOD_ODD));

	// The remainder of the magnitude is turned into a floor remainder for negative values.
	assign r = (neg_q && rem_q != '0) ? UNITS_R - rem_q : rem_q;
	assign result = pos_q ? r + ANGLE_W'(1) : r;

	always_ff @(posedge clk) begin
		if (load_prod) begin
			prod_s1 <= $signed(fifo_rdata) * gear_gain;
		end
		if (load_mag) begin
			neg_q <= v[Q_W-1];
			pos_q <= q_pos;
			mag_q <= v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
		end
		if (fold_step) begin
			fold1_q <= fold1;
			low_q <= mag_q[MOD_LOW_W-1:0];
		end
		if (reduce_step) begin
			fold_q <= fold3;
		end
		if (mod_step) begin
			rem_q <= {odd_rem, low_q};
		end
		if (out_load) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = ~out_valid_q;
	assign output_angle = out_q;
	assign status.busy = state_q != B_IDLE;
	assign status.out_load = out_load;

endmodule

### src/multiturn_encoder_angle_unwrap.sv
// Top level of the multi-turn encoder angle unwrap block.
`timescale 1ns / 1ps

// Samples are taken whenever the offset queue has room; skipped samples and
// zero captures give no result. An acted-on sample goes through the back part
// in order, starting when it leaves the two-entry offset queue: the gain
// multiply (B_IDLE), the floor shift (B_SCALE), folding the magnitude into a
// small value with the same remainder by 45 (B_FOLD, B_REDUCE), that remainder
// by reciprocal multiplication (B_MOD), and the load of the output register
// (B_OUT), which waits while an untaken result is held. The back takes a new
// offset only once the last one is loaded, which sets the sustained rate of
// acted-on samples; input stalls whenever the queue is full. The gain register
// (index 0) and the fire interval register (index 1) should be written only
// while the block is idle.
module multiturn_encoder_angle_unwrap #(
	parameter int unsigned TURN_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [TURN_BITS-1:0]                turn_count,
	input  logic [muaw_pkg::ANGLE_W-1:0]        single_turn_angle,
	input  logic                                zero_request,
	output logic                                empty,
	input  logic                                pop,
	output logic [muaw_pkg::ANGLE_W-1:0]        output_angle,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [muaw_pkg::GAIN_W-1:0]         cfg_data
);
	import muaw_pkg::*;

	localparam int unsigned OFF_W = TURN_BITS + 16;

	logic signed [GAIN_W-1:0]  gear_gain_q;
	logic [INTERVAL_W-1:0]     fire_interval_q;

	muaw_fifo_status_t         fifo_status;
	muaw_back_status_t         back_status;
	logic                      fifo_push;
	logic                      fifo_pop;
	logic [OFF_W-1:0]          fifo_wdata;
	logic [OFF_W-1:0]          fifo_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_gain_q <= GAIN_RESET;
			fire_interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GEAR_GAIN: gear_gain_q <= $signed(cfg_data);
				CFG_FIRE_INTERVAL: fire_interval_q <= cfg_data[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	muaw_front #(
		.TURN_BITS(TURN_BITS),
		.OFF_W(OFF_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.turn_count(turn_count),
		.single_turn_angle(single_turn_angle),
		.zero_request(zero_request),
		.fire_interval(fire_interval_q),
		.fifo_status(fifo_status),
		.fifo_push(fifo_push),
		.fifo_wdata(fifo_wdata)
	);

	muaw_fifo #(
		.WIDTH(OFF_W)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(fifo_push),
		.wdata(fifo_wdata),
		.pop(fifo_pop),
		.rdata(fifo_rdata),
		.status(fifo_status)
	);

	muaw_back #(
		.OFF_W(OFF_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.fifo_rdata(fifo_rdata),
		.fifo_status(fifo_status),
		.fifo_pop(fifo_pop),
		.gear_gain(gear_gain_q),
		.pop(pop),
		.empty(empty),
		.output_angle(output_angle),
		.status(back_status)
	);

	assign full = fifo_status.full;

	// A result on the output never lies outside one turn.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> output_angle <= ANGLE_W'(TURN_UNITS))
		else $error("output angle beyond one turn");

	// The back only loads a new result while it is working on an item.
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.out_load |-> back_status.busy)
		else $error("result loaded while back is idle");

	// A queued offset is picked up by the back in the next cycle once it is idle.
	a_queue_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!back_status.busy && !fifo_status.empty) |=> back_status.busy)
		else $error("queued item not taken by idle back");

	// Taking the only result with none being loaded leaves the output empty.
	a_pop_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !back_status.out_load) |=> empty)
		else $error("result item repeated after pop");

endmodule

### verif/multiturn_encoder_angle_unwrap_test.sv
// Self-checking testbench for the multi-turn encoder angle unwrap block.
`timescale 1ns / 1ps

module multiturn_encoder_angle_unwrap_test;
	import muaw_pkg::*;

	localparam int TURN_BITS = 12;
	localparam longint TURN_SPAN = longint'(1) << TURN_BITS;
	localparam longint UNITS = TURN_UNITS;
	// Cycles allowed for a skipped or captured sample still inside the block.
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		logic [TURN_BITS-1:0] turns;
		logic [ANGLE_W-1:0]   angle;
		logic                 req;
	} sample_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [TURN_BITS-1:0] turn_count = '0;
	logic [ANGLE_W-1:0]   single_turn_angle = '0;
	logic                 zero_request = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [ANGLE_W-1:0]   output_angle;
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = CFG_GEAR_GAIN;
	logic [GAIN_W-1:0]    cfg_data = '0;

	multiturn_encoder_angle_unwrap #(
		.TURN_BITS(TURN_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.turn_count(turn_count),
		.single_turn_angle(single_turn_angle),
		.zero_request(zero_request),
		.empty(empty),
		.pop(pop),
		.output_angle(output_angle),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the configuration and of the block's state.
	logic signed [GAIN_W-1:0] gain_now = GAIN_RESET;
	logic [INTERVAL_W-1:0]    interval_now = INTERVAL_RESET;
	int                       skip_count = 0;
	logic                     capture_pending = 1'b0;
	logic [TURN_BITS-1:0]     zero_turns = TURN_BITS'(ZERO_TURNS_RESET);
	logic [ANGLE_W-1:0]       zero_angle = ZERO_ANGLE_RESET;

	sample_t            sample_q[$];
	logic [ANGLE_W-1:0] pending_angles[$];
	sample_t            cur_sample;
	logic [ANGLE_W-1:0] want_angle;

	int send_idle = 0;
	int recv_stall = 0;
	bit send_pause = 1'b0;
	bit recv_hold = 1'b0;
	bit hold_go = 1'b0;
	int req_pct = 8;
	logic [TURN_BITS-1:0] anchor_turn = TURN_BITS'(ZERO_TURNS_RESET);

	int n_errors = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_writes = 0;

	task automatic note_failure(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		n_errors++;
	endtask

	// Works out the output angle, if any, that one accepted sample causes.
	task automatic unwrap_sample(input sample_t s);
		logic [TURN_BITS-1:0] d;
		longint turn_diff;
		longint offset;
		longint q;
		longint r;
		capture_pending |= s.req;
		if (skip_count + 1 <= int'(interval_now)) begin
			skip_count++;
			return;
		end
		skip_count = 0;
		if (capture_pending) begin
			zero_turns = s.turns;
			zero_angle = s.angle;
			capture_pending = 1'b0;
			return;
		end
		d = s.turns - zero_turns;
		turn_diff = d[TURN_BITS-1] ? longint'(d) - TURN_SPAN : longint'(d);
		offset = turn_diff * UNITS + (longint'(s.angle) - longint'(zero_angle));
		q = (offset * longint'(gain_now)) >>> GAIN_FRAC;
		if (q > 0) begin
			r = ((q - 1) % UNITS) + 1;
		end else begin
			r = q % UNITS;
			if (r < 0)
				r += UNITS;
		end
		pending_angles.push_back(ANGLE_W'(r));
	endtask

	// Sender: offers queued samples, holding each one while the block is full.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			turn_count <= '0;
			single_turn_angle <= '0;
			zero_request <= 1'b0;
		end else begin
			if (push && !full) begin
				unwrap_sample(cur_sample);
				n_accepted++;
			end
			if (!(push && full)) begin
				if (sample_q.size() != 0 && !send_pause && $urandom_range(99) >= send_idle) begin
					cur_sample = sample_q.pop_front();
					push <= 1'b1;
					turn_count <= cur_sample.turns;
					single_turn_angle <= cur_sample.angle;
					zero_request <= cur_sample.req;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every item taken from the result side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				n_results++;
				if (pending_angles.size() == 0) begin
					note_failure($sformatf("unexpected output angle %0d", output_angle));
				end else begin
					want_angle = pending_angles.pop_front();
					if (output_angle !== want_angle)
						note_failure($sformatf("output angle %0d, expected %0d",
							output_angle, want_angle));
				end
			end
			pop <= !recv_hold && ($urandom_range(99) >= recv_stall);
		end
	end

	// Holds the receiver off for a fixed number of cycles each time a hold is started.
	initial begin
		forever begin
			@(posedge hold_go);
			recv_hold = 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			recv_hold = 1'b0;
		end
	end

	task automatic write_reg(input logic idx, input logic [GAIN_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_GEAR_GAIN)
			gain_now = val;
		else
			interval_now = val[INTERVAL_W-1:0];
		n_writes++;
	endtask

	task automatic add(input int turns, input int angle, input bit req);
		sample_q.push_back('{TURN_BITS'(turns), ANGLE_W'(angle), req});
	endtask

	// Waits until every sample is in, every angle is out and the block is quiet.
	task automatic drain();
		while (sample_q.size() != 0 || push)
			@(negedge clk);
		while (pending_angles.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(2))
			0: return $urandom();
			1: return GAIN_RESET;
			default: return GAIN_W'(int'($urandom_range(1 << 25)) - (1 << 24));
		endcase
	endfunction

	// Mostly runs of samples near a fresh zero point, with some noise mixed in.
	function automatic sample_t make_sample();
		sample_t s;
		int pick;
		int a;
		pick = $urandom_range(99);
		s.req = 1'b0;
		if (pick < req_pct) begin
			anchor_turn = TURN_BITS'($urandom());
			s.turns = anchor_turn;
			s.req = 1'b1;
		end else if (pick < 20) begin
			s.turns = TURN_BITS'($urandom());
			s.req = ($urandom_range(99) < 2);
		end else if (pick < 27) begin
			// Turn difference at the edges of the signed wrap.
			s.turns = anchor_turn + TURN_BITS'($urandom_range(1) ? $urandom_range(2046, 2050)
				: -$urandom_range(2046, 2050));
		end else begin
			s.turns = anchor_turn + TURN_BITS'($urandom_range(6)) - TURN_BITS'(3);
		end
		a = $urandom_range(99);
		if (a < 80)
			s.angle = ANGLE_W'($urandom_range(TURN_UNITS - 1));
		else if (a < 90)
			s.angle = ANGLE_W'($urandom_range(32767, TURN_UNITS));
		else
			case ($urandom_range(3))
				0: s.angle = '0;
				1: s.angle = ANGLE_W'(TURN_UNITS - 1);
				2: s.angle = ANGLE_W'(TURN_UNITS);
				default: s.angle = '1;
			endcase
		return s;
	endfunction

	task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
		send_idle = idle_pct;
		recv_stall = stall_pct;
		repeat (n) sample_q.push_back(make_sample());
		drain();
	endtask

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$display("Timed out with %0d samples queued and %0d angles outstanding.",
			sample_q.size(), pending_angles.size());
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		// Reset values of both registers and of the zero point.
		req_pct = 0;
		run_phase(33, 0, 0);

		// Directed samples with every sample acted on.
		write_reg(CFG_FIRE_INTERVAL, 32'd0);
		add(16, 20288, 0);
		add(0, 0, 0);
		add(4095, 32767, 0);
		add(16 + 2047, 0, 0);
		add(16 + 2048, 23039, 0);
		add(5, 100, 1);
		add(5, 100, 0);
		add(6, 100, 0);
		drain();
		// Unity gain puts exact multiples of a turn on the wrap boundary.
		write_reg(CFG_GEAR_GAIN, 32'h0100_0000);
		add(0, 0, 1);
		add(1, 0, 0);
		add(4095, 0, 0);
		add(0, 0, 0);
		add(0, 23039, 0);
		add(0, 32767, 0);
		drain();
		write_reg(CFG_GEAR_GAIN, 32'h7FFF_FFFF);
		add(2047, 32767, 0);
		add(2048, 0, 0);
		drain();
		write_reg(CFG_GEAR_GAIN, 32'h8000_0000);
		add(2047, 32767, 0);
		add(2048, 0, 0);
		drain();
		write_reg(CFG_GEAR_GAIN, 32'd0);
		add(1234, 555, 0);
		drain();
		// A request on a skipped sample is held for the next acted-on one.
		write_reg(CFG_FIRE_INTERVAL, 32'd1);
		write_reg(CFG_GEAR_GAIN, GAIN_RESET);
		add(7, 7, 1);
		add(9, 9, 0);
		add(10, 10, 0);
		add(10, 23039, 0);
		drain();

		req_pct = 8;
		write_reg(CFG_FIRE_INTERVAL, 32'd0);
		write_reg(CFG_GEAR_GAIN, rand_gain());
		run_phase(60, 0, 0);

		write_reg(CFG_FIRE_INTERVAL, 32'd2);
		write_reg(CFG_GEAR_GAIN, GAIN_RESET);
		run_phase(80, 87, 0);

		write_reg(CFG_FIRE_INTERVAL, 32'd1);
		write_reg(CFG_GEAR_GAIN, rand_gain());
		run_phase(80, 0, 87);

		// The sender stops halfway until every outstanding angle has come out.
		write_reg(CFG_FIRE_INTERVAL, GAIN_W'($urandom_range(5)));
		write_reg(CFG_GEAR_GAIN, rand_gain());
		send_idle = 20;
		recv_stall = 20;
		repeat (80) sample_q.push_back(make_sample());
		while (sample_q.size() > 40)
			@(negedge clk);
		send_pause = 1'b1;
		while (pending_angles.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		send_pause = 1'b0;
		drain();

		// The receiver holds off long enough for the block to fill and stall input.
		write_reg(CFG_FIRE_INTERVAL, 32'd0);
		write_reg(CFG_GEAR_GAIN, rand_gain());
		send_idle = 0;
		recv_stall = 0;
		repeat (40) sample_q.push_back(make_sample());
		hold_go = 1'b1;
		@(negedge clk);
		wait (!recv_hold);
		hold_go = 1'b0;
		drain();

		// Widest interval: only every 256th sample is acted on.
		req_pct = 0;
		write_reg(CFG_FIRE_INTERVAL, 32'd255);
		write_reg(CFG_GEAR_GAIN, rand_gain());
		run_phase(257, 20, 20);

		if (pending_angles.size() != 0)
			note_failure($sformatf("%0d output angles never arrived", pending_angles.size()));
		$display("Run covered %0d samples and %0d checked output angles over %0d register writes,",
			n_accepted, n_results, n_writes);
		$display("including both wrap boundaries, gain extremes and fire intervals 0 to 255.");
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
